// ===== rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define PVI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define PVI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pvi_pkg.sv =====
// ============================================================================
// pvi_pkg
// Shared constants for the point vortex induced velocity block.
// ============================================================================
`timescale 1ns / 1ps

package pvi_pkg;

    // Default sizes
    localparam int MAX_VORTICES_DEF = 64;
    localparam int COORD_WIDTH_DEF  = 24;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int TIDX_W = 6;
    localparam int VEL_W  = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // Quotient width and round(2^32 / (2*pi))
    localparam int          QUO_W   = 34;
    localparam int          INV_W   = 30;
    localparam logic [29:0] INV_2PI = 30'd683565276;

    // Depth of the queue between front and back (power of two)
    localparam int Q_DEPTH = 4;

endpackage

// ===== rtl/pvi_req_if.sv =====
// ============================================================================
// pvi_req_if
// Request channel: clear, append or query transactions.
// ============================================================================
`timescale 1ns / 1ps

interface pvi_req_if import pvi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [REQ_W-1:0]              req_type;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] strength;
    logic [TIDX_W-1:0]             target_index;

    modport source (
        output valid, req_type, pos_x, pos_y, strength, target_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, strength, target_index,
        output ready
    );
endinterface

// ===== rtl/pvi_vel_if.sv =====
// ============================================================================
// pvi_vel_if
// Result channel: conjugate velocity at a query target.
// ============================================================================
`timescale 1ns / 1ps

interface pvi_vel_if import pvi_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] vel_real;
    logic signed [VEL_W-1:0] vel_imag;
    logic                    saturated;

    modport source (
        output valid, vel_real, vel_imag, saturated,
        input  ready
    );
    modport sink (
        input  valid, vel_real, vel_imag, saturated,
        output ready
    );
endinterface

// ===== rtl/pvi_fifo.sv =====
// ============================================================================
// pvi_fifo
// Small register queue that decouples the front from the back.
// ============================================================================
`timescale 1ns / 1ps

module pvi_fifo import pvi_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/pvi_front.sv =====
// ============================================================================
// pvi_front
// Accepts request transactions, drops unknown codes, packs them for the queue.
// ============================================================================
`timescale 1ns / 1ps

module pvi_front import pvi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int QW          = REQ_W + 3 * COORD_WIDTH + TIDX_W
) (
    input  logic          clk,
    input  logic          rst_n,
    pvi_req_if.sink       req,
    output logic          q_valid,
    input  logic          q_ready,
    output logic [QW-1:0] q_data
);
    logic          valid_reg;
    logic [QW-1:0] data_reg;
    logic          known;

    assign req.ready = !valid_reg || q_ready;
    assign q_valid   = valid_reg;
    assign q_data    = data_reg;

    // Only clear, append and query go on; other codes vanish here
    always_comb
    begin
        known = req.req_type inside {REQ_CLEAR, REQ_APPEND, REQ_QUERY};
    end

    always_ff @(posedge clk)
    begin
        if (req.ready)
        begin
            data_reg <= {req.req_type, req.pos_x, req.pos_y, req.strength,
                         req.target_index};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid && known;
        end
    end
endmodule

// ===== rtl/pvi_back.sv =====
// ============================================================================
// pvi_back
// Vortex store and the per-vortex velocity engine with output register.
// ============================================================================
`timescale 1ns / 1ps

module pvi_back import pvi_pkg::*; #(
    parameter int MAX_VORTICES = MAX_VORTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int QW           = REQ_W + 3 * COORD_WIDTH + TIDX_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [QW-1:0] q_data,
    pvi_vel_if.source     vel
);
    localparam int W     = COORD_WIDTH;
    localparam int IW    = (MAX_VORTICES > 1) ? $clog2(MAX_VORTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VORTICES + 1);
    localparam int KW    = (IW > TIDX_W) ? IW : TIDX_W;
    localparam int A_W   = 2 * W;
    localparam int R2_W  = 2 * W + 1;
    localparam int DD    = R2_W + QUO_W;
    localparam int HALF  = QUO_W / 2;
    localparam int P_W   = HALF + INV_W;
    localparam int SUM_W = VEL_W + CNT_W + 1;

    // State codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FETCH = 4'd1;
    localparam logic [3:0] ST_DIFF  = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_CHK   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_NEXT  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    // Queue entry fields
    logic [REQ_W-1:0]  e_type;
    logic [W-1:0]      e_x;
    logic [W-1:0]      e_y;
    logic [W-1:0]      e_s;
    logic [TIDX_W-1:0] e_tidx;

    assign {e_type, e_x, e_y, e_s, e_tidx} = q_data;

    // Vortex store
    logic [W-1:0] mem_x [MAX_VORTICES];
    logic [W-1:0] mem_y [MAX_VORTICES];
    logic [W-1:0] mem_s [MAX_VORTICES];
    logic [W-1:0] rd_x_reg;
    logic [W-1:0] rd_y_reg;
    logic [W-1:0] rd_s_reg;

    logic [3:0]        state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IW-1:0]     j_reg;
    logic [W-1:0]      tx_reg;
    logic [W-1:0]      ty_reg;
    logic [TIDX_W-1:0] tidx_reg;

    logic [W-1:0]      adx_reg;
    logic [W-1:0]      ady_reg;
    logic [W-1:0]      ag_reg;
    logic              dx_neg_reg;
    logic              dy_neg_reg;
    logic              g_neg_reg;
    logic [R2_W-1:0]   r2_reg;
    logic [A_W-1:0]    are_reg;
    logic [A_W-1:0]    aim_reg;
    logic [DD-1:0]     n_re_reg;
    logic [DD-1:0]     n_im_reg;
    logic [DD-1:0]     dvs_reg;
    logic              ovf_re_reg;
    logic              ovf_im_reg;
    logic [5:0]        cnt_reg;
    logic [QUO_W-1:0]  q_re_reg;
    logic [QUO_W-1:0]  q_im_reg;
    logic [P_W-1:0]    p_re_lo_reg;
    logic [P_W-1:0]    p_re_hi_reg;
    logic [P_W-1:0]    p_im_lo_reg;
    logic [P_W-1:0]    p_im_hi_reg;
    logic [SUM_W-1:0]  sum_re_reg;
    logic [SUM_W-1:0]  sum_im_reg;
    logic              sat_reg;

    logic              out_valid_reg;
    logic [VEL_W-1:0]  out_re_reg;
    logic [VEL_W-1:0]  out_im_reg;
    logic              out_sat_reg;

    logic              wr_en;
    logic              not_full;
    logic              skip;
    logic              last;
    logic [W:0]        dx_w;
    logic [W:0]        dy_w;
    logic [W-1:0]      adx;
    logic [W-1:0]      ady;
    logic [W-1:0]      ag;
    logic [A_W-1:0]    sqx;
    logic [A_W-1:0]    sqy;
    logic [A_W-1:0]    prod_re;
    logic [A_W-1:0]    prod_im;
    logic [DD-1:0]     n_re0;
    logic [DD-1:0]     n_im0;
    logic [DD-1:0]     r2_top;
    logic              ge_re;
    logic              ge_im;
    logic [P_W-1:0]    m_re_lo;
    logic [P_W-1:0]    m_re_hi;
    logic [P_W-1:0]    m_im_lo;
    logic [P_W-1:0]    m_im_hi;
    logic [63:0]       full_re;
    logic [63:0]       full_im;
    logic [VEL_W-1:0]  mag_re;
    logic [VEL_W-1:0]  mag_im;
    logic              big_re;
    logic              big_im;
    logic [VEL_W:0]    term_re;
    logic [VEL_W:0]    term_im;
    logic [VEL_W-1:0]  cl_re;
    logic [VEL_W-1:0]  cl_im;
    logic              cl_re_sat;
    logic              cl_im_sat;
    logic              out_load;

    assign q_ready  = (state_reg == ST_IDLE);
    assign not_full = (count_reg < CNT_W'(MAX_VORTICES));
    assign wr_en    = q_ready && q_valid && (e_type == REQ_APPEND) && not_full;
    assign skip     = (KW'(j_reg) == KW'(tidx_reg));
    assign last     = ((CNT_W'(j_reg) + 1'b1) == count_reg);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || vel.ready);

    assign vel.valid     = out_valid_reg;
    assign vel.vel_real  = out_re_reg;
    assign vel.vel_imag  = out_im_reg;
    assign vel.saturated = out_sat_reg;

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[count_reg[IW-1:0]] <= e_x;
            mem_y[count_reg[IW-1:0]] <= e_y;
            mem_s[count_reg[IW-1:0]] <= e_s;
        end
        rd_x_reg <= mem_x[j_reg];
        rd_y_reg <= mem_y[j_reg];
        rd_s_reg <= mem_s[j_reg];
    end

    // Differences and magnitudes
    always_comb
    begin
        dx_w = {tx_reg[W-1], tx_reg} - {rd_x_reg[W-1], rd_x_reg};
        dy_w = {ty_reg[W-1], ty_reg} - {rd_y_reg[W-1], rd_y_reg};
        adx  = dx_w[W] ? W'(~dx_w + 1'b1) : dx_w[W-1:0];
        ady  = dy_w[W] ? W'(~dy_w + 1'b1) : dy_w[W-1:0];
        ag   = rd_s_reg[W-1] ? (~rd_s_reg + 1'b1) : rd_s_reg;
    end

    // Squares and numerators
    assign sqx     = A_W'(adx_reg) * A_W'(adx_reg);
    assign sqy     = A_W'(ady_reg) * A_W'(ady_reg);
    assign prod_re = A_W'(ag_reg) * A_W'(ady_reg);
    assign prod_im = A_W'(ag_reg) * A_W'(adx_reg);

    // Division setup and one restoring step per cycle
    assign n_re0  = DD'({are_reg, 16'd0});
    assign n_im0  = DD'({aim_reg, 16'd0});
    assign r2_top = {r2_reg, {QUO_W{1'b0}}};
    assign ge_re  = (n_re_reg >= dvs_reg);
    assign ge_im  = (n_im_reg >= dvs_reg);

    // Quotient times 1/(2*pi), split into two partial products
    assign m_re_lo = P_W'(q_re_reg[HALF-1:0]) * P_W'(INV_2PI);
    assign m_re_hi = P_W'(q_re_reg[QUO_W-1:HALF]) * P_W'(INV_2PI);
    assign m_im_lo = P_W'(q_im_reg[HALF-1:0]) * P_W'(INV_2PI);
    assign m_im_hi = P_W'(q_im_reg[QUO_W-1:HALF]) * P_W'(INV_2PI);

    // Rounded magnitude and signed, clamped term
    always_comb
    begin
        full_re = 64'({p_re_hi_reg, {HALF{1'b0}}}) + 64'(p_re_lo_reg) + 64'h8000_0000;
        full_im = 64'({p_im_hi_reg, {HALF{1'b0}}}) + 64'(p_im_lo_reg) + 64'h8000_0000;
        mag_re  = full_re[63:32];
        mag_im  = full_im[63:32];
        if (g_neg_reg == dy_neg_reg)
        begin
            big_re  = ovf_re_reg || (mag_re > 32'h8000_0000);
            term_re = big_re ? 33'h1_8000_0000 : (33'd0 - {1'b0, mag_re});
        end
        else
        begin
            big_re  = ovf_re_reg || mag_re[31];
            term_re = big_re ? 33'h0_7FFF_FFFF : {1'b0, mag_re};
        end
        if (g_neg_reg == dx_neg_reg)
        begin
            big_im  = ovf_im_reg || (mag_im > 32'h8000_0000);
            term_im = big_im ? 33'h1_8000_0000 : (33'd0 - {1'b0, mag_im});
        end
        else
        begin
            big_im  = ovf_im_reg || mag_im[31];
            term_im = big_im ? 33'h0_7FFF_FFFF : {1'b0, mag_im};
        end
    end

    // Final sum clamp to 32 bits
    always_comb
    begin
        cl_re_sat = !((&sum_re_reg[SUM_W-1:VEL_W-1]) || !(|sum_re_reg[SUM_W-1:VEL_W-1]));
        cl_im_sat = !((&sum_im_reg[SUM_W-1:VEL_W-1]) || !(|sum_im_reg[SUM_W-1:VEL_W-1]));
        if (cl_re_sat)
        begin
            cl_re = sum_re_reg[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            cl_re = sum_re_reg[VEL_W-1:0];
        end
        if (cl_im_sat)
        begin
            cl_im = sum_im_reg[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            cl_im = sum_im_reg[VEL_W-1:0];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                tx_reg     <= e_x;
                ty_reg     <= e_y;
                tidx_reg   <= e_tidx;
                sum_re_reg <= '0;
                sum_im_reg <= '0;
            end
            ST_DIFF:
            begin
                adx_reg    <= adx;
                ady_reg    <= ady;
                ag_reg     <= ag;
                dx_neg_reg <= dx_w[W];
                dy_neg_reg <= dy_w[W];
                g_neg_reg  <= rd_s_reg[W-1];
            end
            ST_SQ:
            begin
                r2_reg  <= {1'b0, sqx} + {1'b0, sqy};
                are_reg <= prod_re;
                aim_reg <= prod_im;
            end
            ST_CHK:
            begin
                n_re_reg   <= n_re0;
                n_im_reg   <= n_im0;
                ovf_re_reg <= (n_re0 >= r2_top);
                ovf_im_reg <= (n_im0 >= r2_top);
                dvs_reg    <= r2_top >> 1;
                q_re_reg   <= '0;
                q_im_reg   <= '0;
            end
            ST_DIV:
            begin
                if (ge_re)
                begin
                    n_re_reg <= n_re_reg - dvs_reg;
                end
                if (ge_im)
                begin
                    n_im_reg <= n_im_reg - dvs_reg;
                end
                q_re_reg <= {q_re_reg[QUO_W-2:0], ge_re};
                q_im_reg <= {q_im_reg[QUO_W-2:0], ge_im};
                dvs_reg  <= dvs_reg >> 1;
            end
            ST_MUL:
            begin
                p_re_lo_reg <= m_re_lo;
                p_re_hi_reg <= m_re_hi;
                p_im_lo_reg <= m_im_lo;
                p_im_hi_reg <= m_im_hi;
            end
            ST_ACC:
            begin
                sum_re_reg <= sum_re_reg + {{(SUM_W-VEL_W-1){term_re[VEL_W]}}, term_re};
                sum_im_reg <= sum_im_reg + {{(SUM_W-VEL_W-1){term_im[VEL_W]}}, term_im};
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_re_reg  <= cl_re;
            out_im_reg  <= cl_im;
            out_sat_reg <= sat_reg || cl_re_sat || cl_im_sat;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Result register: load a new velocity or release the taken one
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (vel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    j_reg   <= '0;
                    sat_reg <= 1'b0;
                    if (q_valid)
                    begin
                        case (e_type)
                            REQ_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            REQ_APPEND:
                            begin
                                if (not_full)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            REQ_QUERY:
                            begin
                                state_reg <= (count_reg == '0) ? ST_OUT : ST_FETCH;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= skip ? ST_NEXT : ST_DIFF;
                end
                ST_DIFF:
                begin
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (r2_reg == '0)
                    begin
                        // coincident point: no contribution, flag it
                        sat_reg   <= 1'b1;
                        state_reg <= ST_NEXT;
                    end
                    else
                    begin
                        cnt_reg   <= 6'(QUO_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    sat_reg   <= sat_reg || big_re || big_im;
                    state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (last)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/point_vortex_induced_velocity.sv =====
// ============================================================================
// point_vortex_induced_velocity
// Conjugate velocity induced by a store of 2D point vortices, fixed point.
// ============================================================================
// Clear and append transactions are handled in the back engine's idle state.
// A query walks the stored vortices one at a time through a single shared
// pair unit: store read, differences, squares, a restoring divider with a
// QUO_W-bit quotient for both components, scaling, accumulate; the target's
// own slot is skipped and a coincident vortex only sets the saturated flag.
// A four-entry queue behind the request port keeps accepting transactions,
// until it fills, while a query runs, and the result register lets the next
// query start while a velocity waits to be taken.
`timescale 1ns / 1ps

module point_vortex_induced_velocity import pvi_pkg::*; #(
    parameter int MAX_VORTICES = MAX_VORTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    pvi_req_if.sink   req,
    pvi_vel_if.source vel
);
    localparam int QW = REQ_W + 3 * COORD_WIDTH + TIDX_W;

    logic          f_valid;
    logic          f_ready;
    logic [QW-1:0] f_data;
    logic          b_valid;
    logic          b_ready;
    logic [QW-1:0] b_data;

    pvi_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .QW          (QW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_data  (f_data)
    );

    pvi_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    pvi_back #(
        .MAX_VORTICES (MAX_VORTICES),
        .COORD_WIDTH  (COORD_WIDTH),
        .QW           (QW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_data  (b_data),
        .vel     (vel)
    );
endmodule

// ===== rtl/pvi_checker.sv =====
// ============================================================================
// pvi_checker
// Port-level checks on the velocity block, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pvi_checker import pvi_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic [REQ_W-1:0] req_type,
    input logic             vel_valid,
    input logic             vel_ready,
    input logic [VEL_W-1:0] vel_real,
    input logic [VEL_W-1:0] vel_imag,
    input logic             saturated
);
    logic [15:0] pending_reg;
    logic        q_in;
    logic        q_out;

    assign q_in  = req_valid && req_ready && (req_type == REQ_QUERY);
    assign q_out = vel_valid && vel_ready;

    // Queries accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (q_in && !q_out)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (q_out && !q_in)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `PVI_ASSERT(a_vel_hold, vel_valid && !vel_ready |=> vel_valid, "result dropped while stalled")
    `PVI_ASSERT(a_vel_stable, vel_valid && !vel_ready |=> $stable(vel_real) && $stable(vel_imag) && $stable(saturated), "result changed while stalled")
    `PVI_ASSERT(a_vel_has_query, vel_valid |-> pending_reg != 16'd0, "result without a query")
    `PVI_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !vel_valid, "result shown during reset")
endmodule

bind point_vortex_induced_velocity pvi_checker u_pvi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .vel_valid (vel.valid),
    .vel_ready (vel.ready),
    .vel_real  (vel.vel_real),
    .vel_imag  (vel.vel_imag),
    .saturated (vel.saturated)
);
